/* sv/pulse_flow_meter_assert.svh */
// Assertion macros used by the checker file of the pulse flow meter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef PULSE_FLOW_METER_ASSERT_SVH
`define PULSE_FLOW_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PFM_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pulse flow meter check failed");

// Consequent must hold in the cycle after the antecedent.
`define PFM_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pulse flow meter check failed");

`endif

/* sv/pfm_pkg.sv */
// Package of the pulse flow meter: transaction types, opcodes, register indexes
// and fixed constants. No dependencies.
package pfm_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] time_us;
    } pfm_in_t;

    typedef struct packed {
        logic [31:0] flow_milli_lpm;
        logic [31:0] count_value;
        logic [31:0] volume_ml;
        logic [31:0] total_volume_ml;
    } pfm_out_t;

    typedef enum logic [2:0] {
        OP_EDGE       = 3'd0,
        OP_FLOW       = 3'd1,
        OP_RD_MINUTE  = 3'd2,
        OP_RD_HOUR    = 3'd3,
        OP_RD_TOTAL   = 3'd4,
        OP_RD_CAL     = 3'd5,
        OP_CLR_CAL    = 3'd6,
        OP_LOAD_TOTAL = 3'd7
    } pfm_op_t;

    typedef enum logic [2:0] {
        REG_DEBOUNCE    = 3'd0,
        REG_STALE       = 3'd1,
        REG_K_FACTOR    = 3'd2,
        REG_PULSES_PER_L = 3'd3,
        REG_TOTAL_START = 3'd4
    } pfm_reg_t;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [31:0] DEBOUNCE_RST = 32'd2000;
    localparam logic [31:0] STALE_RST    = 32'd5000000;
    localparam logic [15:0] K_FACTOR_RST = 16'd1920;
    localparam logic [15:0] PPL_RST      = 16'd450;

    // Divider operand width and step counter width.
    localparam int unsigned DIV_W     = 48;
    localparam int unsigned DIV_CNT_W = 6;

    localparam logic [31:0]      SINGLE_WAIT_US = 32'd200000;
    localparam logic [DIV_W-1:0] FLOW_SCALE     = 48'd256000000000;
    localparam logic [DIV_W-1:0] ML_PER_L       = 48'd1000;
    localparam logic [31:0]      SAT32          = 32'hFFFF_FFFF;

endpackage

/* sv/pulse_flow_meter.sv */
// Pulse flow meter. An edge transaction is checked and stored in S_EDGE. Flow queries and
// count reads use the shared 48-step restoring divider (one quotient bit per cycle),
// at most one division per flow query and two per count read; opcodes 6 and 7
// complete in the accept cycle. The pulse-time ring lives in a one-read-port RAM, so
// a query reads the newest and the oldest time one after the other. No item is taken
// while one is in work; a finished result waits in S_OUT until the output register
// is free, and holds the block meanwhile. Uses pfm_pkg, pfm_ram.
module pulse_flow_meter
    import pfm_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pfm_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pfm_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_FCHK, S_RD_OLD, S_SPAN, S_MUL, S_CNT, S_DIV, S_DIVEND, S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic [31:0]         time_reg, time_next;
    logic [31:0]         last_reg, last_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [31:0]         held_reg, held_next;
    logic [31:0]         minute_reg, minute_next;
    logic [31:0]         hour_reg, hour_next;
    logic [31:0]         total_reg, total_next;
    logic [31:0]         cal_reg, cal_next;
    logic [31:0]         debounce_reg, debounce_next;
    logic [31:0]         stale_reg, stale_next;
    logic [15:0]         k_reg, k_next;
    logic [15:0]         ppl_reg, ppl_next;
    logic [31:0]         tstart_reg, tstart_next;
    logic                single_reg, single_next;
    logic                vol_phase_reg, vol_phase_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                m_valid_reg, m_valid_next;

    logic [31:0]         newest_reg, newest_next;
    logic [31:0]         mul_a_reg, mul_a_next;
    logic [DIV_W-1:0]    div_num_reg, div_num_next;
    logic [DIV_W-1:0]    div_den_reg, div_den_next;
    logic [DIV_W-1:0]    div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]    div_quo_reg, div_quo_next;
    logic                div_numz_reg, div_numz_next;
    pfm_out_t            res_reg, res_next;
    pfm_out_t            m_data_reg, m_data_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [31:0]         ram_rdata;

    logic [31:0]         gap;
    logic [31:0]         span;
    logic                stale_hit;
    logic [IDX_W-1:0]    wr_eff;
    logic [FILL_W-1:0]   fill_eff;
    logic [FILL_W-1:0]   wr_ext;
    logic [IDX_W-1:0]    oldest_idx;
    logic [IDX_W-1:0]    newest_idx;
    logic [DIV_W:0]      rem_sh;
    logic                rem_ge;
    logic [31:0]         q_sat;
    logic [DIV_W-1:0]    num_ml;
    logic                s_hs;

    pfm_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (time_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_hs      = s_valid && s_ready;

    always_comb begin
        gap        = time_reg - last_reg;
        span       = newest_reg - ram_rdata;
        stale_hit  = (fill_reg != '0) && (gap > stale_reg);
        wr_eff     = stale_hit ? '0 : wr_idx_reg;
        fill_eff   = stale_hit ? '0 : fill_reg;
        wr_ext     = FILL_W'(wr_idx_reg);
        oldest_idx = (wr_ext >= fill_reg) ? IDX_W'(wr_ext - fill_reg)
                                          : IDX_W'(wr_ext + DEPTH_F - fill_reg);
        newest_idx = (wr_idx_reg == '0) ? LAST_IDX : wr_idx_reg - 1'b1;
        rem_sh     = {div_rem_reg, div_num_reg[DIV_W-1]};
        rem_ge     = rem_sh >= {1'b0, div_den_reg};
        num_ml     = 48'(res_reg.count_value) * ML_PER_L;
        if (div_den_reg == '0) begin
            q_sat = div_numz_reg ? 32'd0 : SAT32;
        end else if (div_quo_reg[DIV_W-1:32] != '0) begin
            q_sat = SAT32;
        end else begin
            q_sat = div_quo_reg[31:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        time_next      = time_reg;
        last_next      = last_reg;
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        held_next      = held_reg;
        minute_next    = minute_reg;
        hour_next      = hour_reg;
        total_next     = total_reg;
        cal_next       = cal_reg;
        debounce_next  = debounce_reg;
        stale_next     = stale_reg;
        k_next         = k_reg;
        ppl_next       = ppl_reg;
        tstart_next    = tstart_reg;
        single_next    = single_reg;
        vol_phase_next = vol_phase_reg;
        div_cnt_next   = div_cnt_reg;
        m_valid_next   = m_valid_reg;
        newest_next    = newest_reg;
        mul_a_next     = mul_a_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_numz_next  = div_numz_reg;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = wr_eff;
        ram_raddr      = newest_idx;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:     debounce_next = cfg_data;
                REG_STALE:        stale_next    = cfg_data;
                REG_K_FACTOR:     k_next        = cfg_data[15:0];
                REG_PULSES_PER_L: ppl_next      = cfg_data[15:0];
                REG_TOTAL_START:  tstart_next   = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_hs) begin
                    op_next        = s_data.opcode;
                    time_next      = s_data.time_us;
                    res_next       = '0;
                    vol_phase_next = 1'b0;
                    unique case (s_data.opcode)
                        OP_EDGE:       state_next = S_EDGE;
                        OP_FLOW:       state_next = S_FCHK;
                        OP_RD_MINUTE: begin
                            res_next.count_value = minute_reg;
                            minute_next          = '0;
                            state_next           = S_CNT;
                        end
                        OP_RD_HOUR: begin
                            res_next.count_value = hour_reg;
                            hour_next            = '0;
                            state_next           = S_CNT;
                        end
                        OP_RD_TOTAL: begin
                            res_next.count_value = total_reg;
                            state_next           = S_CNT;
                        end
                        OP_RD_CAL: begin
                            res_next.count_value = cal_reg;
                            state_next           = S_CNT;
                        end
                        OP_CLR_CAL:    cal_next   = '0;
                        OP_LOAD_TOTAL: total_next = tstart_reg;
                        default: ;
                    endcase
                end
            end

            S_EDGE: begin
                if (gap >= debounce_reg) begin
                    ram_we      = 1'b1;
                    last_next   = time_reg;
                    wr_idx_next = (wr_eff == LAST_IDX) ? '0 : wr_eff + 1'b1;
                    fill_next   = (fill_eff < DEPTH_F) ? fill_eff + 1'b1 : fill_eff;
                    minute_next = minute_reg + 32'd1;
                    hour_next   = hour_reg + 32'd1;
                    total_next  = total_reg + 32'd1;
                    cal_next    = cal_reg + 32'd1;
                end
                state_next = S_IDLE;
            end

            S_FCHK: begin
                // The newest time is read here in case the ring holds two or more.
                if (fill_reg == '0 || gap > stale_reg) begin
                    held_next = '0;
                    state_next = S_OUT;
                end else if (fill_reg == FILL_W'(1)) begin
                    if (gap >= SINGLE_WAIT_US) begin
                        mul_a_next  = gap;
                        single_next = 1'b1;
                        state_next  = S_MUL;
                    end else begin
                        res_next.flow_milli_lpm = held_reg;
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_RD_OLD;
                end
            end

            S_RD_OLD: begin
                ram_raddr   = oldest_idx;
                newest_next = ram_rdata;
                state_next  = S_SPAN;
            end

            S_SPAN: begin
                if (span == '0) begin
                    res_next.flow_milli_lpm = held_reg;
                    state_next = S_OUT;
                end else begin
                    mul_a_next  = span;
                    single_next = 1'b0;
                    state_next  = S_MUL;
                end
            end

            S_MUL: begin
                div_num_next  = single_reg ? FLOW_SCALE
                                           : 48'(fill_reg - 1'b1) * FLOW_SCALE;
                div_den_next  = 48'(mul_a_reg) * 48'(k_reg);
                div_numz_next = 1'b0;
                div_rem_next  = '0;
                div_quo_next  = '0;
                div_cnt_next  = '0;
                state_next    = S_DIV;
            end

            S_CNT: begin
                div_num_next  = num_ml;
                div_den_next  = 48'(ppl_reg);
                div_numz_next = (res_reg.count_value == '0);
                div_rem_next  = '0;
                div_quo_next  = '0;
                div_cnt_next  = '0;
                state_next    = S_DIV;
            end

            S_DIV: begin
                div_rem_next = rem_ge ? DIV_W'(rem_sh - {1'b0, div_den_reg})
                                      : rem_sh[DIV_W-1:0];
                div_quo_next = {div_quo_reg[DIV_W-2:0], rem_ge};
                div_num_next = {div_num_reg[DIV_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    state_next = S_DIVEND;
                end
            end

            S_DIVEND: begin
                if (op_reg == OP_FLOW) begin
                    held_next               = q_sat;
                    res_next.flow_milli_lpm = q_sat;
                    state_next              = S_OUT;
                end else if (!vol_phase_reg) begin
                    // Second division converts the total count.
                    res_next.volume_ml = q_sat;
                    vol_phase_next     = 1'b1;
                    div_num_next       = 48'(total_reg) * ML_PER_L;
                    div_den_next       = 48'(ppl_reg);
                    div_numz_next      = (total_reg == '0);
                    div_rem_next       = '0;
                    div_quo_next       = '0;
                    div_cnt_next       = '0;
                    state_next         = S_DIV;
                end else begin
                    res_next.total_volume_ml = q_sat;
                    state_next               = S_OUT;
                end
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            held_reg      <= '0;
            minute_reg    <= '0;
            hour_reg      <= '0;
            total_reg     <= '0;
            cal_reg       <= '0;
            debounce_reg  <= DEBOUNCE_RST;
            stale_reg     <= STALE_RST;
            k_reg         <= K_FACTOR_RST;
            ppl_reg       <= PPL_RST;
            tstart_reg    <= '0;
            single_reg    <= 1'b0;
            vol_phase_reg <= 1'b0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            op_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
            minute_reg    <= minute_next;
            hour_reg      <= hour_next;
            total_reg     <= total_next;
            cal_reg       <= cal_next;
            debounce_reg  <= debounce_next;
            stale_reg     <= stale_next;
            k_reg         <= k_next;
            ppl_reg       <= ppl_next;
            tstart_reg    <= tstart_next;
            single_reg    <= single_next;
            vol_phase_reg <= vol_phase_next;
            div_cnt_reg   <= div_cnt_next;
            m_valid_reg   <= m_valid_next;
            op_reg        <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg     <= time_next;
        newest_reg   <= newest_next;
        mul_a_reg    <= mul_a_next;
        div_num_reg  <= div_num_next;
        div_den_reg  <= div_den_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_numz_reg <= div_numz_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule

/* sv/pfm_ram.sv */
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module pfm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/pfm_checker.sv */
// Port-level checker for the pulse flow meter, bound to the top level below.
// Uses pfm_pkg and the macros of pulse_flow_meter_assert.svh.
`include "pulse_flow_meter_assert.svh"

module pfm_checker
    import pfm_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input pfm_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input pfm_out_t m_data
);

    // A stalled result transaction keeps its payload.
    `PFM_AST_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Reset empties the output register.
    `PFM_AST_NXT(a_out_reset, aclk, 1'b1, !aresetn, !m_valid)

    // A flow query keeps the block busy for at least the next cycle.
    `PFM_AST_NXT(a_flow_busy, aclk, aresetn, s_valid && s_ready && s_data.opcode == OP_FLOW, !s_ready)

    // A result carries either a flow or a count, never both.
    `PFM_AST_IMP(a_one_kind, aclk, aresetn, m_valid, m_data.flow_milli_lpm == '0 || m_data.count_value == '0)

endmodule

bind pulse_flow_meter pfm_checker u_pfm_checker (.*);
